// File: hdl/space_vector_pwm_dq_macros.svh
// assertion macros for the space vector pwm checker
`ifndef SPACE_VECTOR_PWM_DQ_MACROS_SVH
`define SPACE_VECTOR_PWM_DQ_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define SVP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svpwm port check failed");

// next-cycle implication, also live during reset
`define SVP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("svpwm port check failed");

`endif

// File: hdl/svpwm_pkg.sv
// shared types, constants and lookup functions for the space vector pwm block
`default_nettype none
package svpwm_pkg;

  localparam int          SINE_ENTRIES_DEF = 1024;
  localparam logic [14:0] LIMIT_RESET      = 15'd27853;
  localparam logic [15:0] SIN_A            = 16'd51472;
  localparam logic [14:0] SIN_B            = 15'd21024;
  localparam logic [11:0] SIN_C            = 12'd2320;
  localparam logic signed [16:0] HALF_SQRT3 = 17'sd28378;

  typedef struct packed {
    logic [15:0]        angle;
    logic signed [15:0] d;
    logic signed [15:0] q;
    logic               limited;
  } svpwm_item_t;

  function automatic logic [2:0] sector_of_k(input logic [2:0] k);
    logic [2:0] s;
    unique case (k)
      3'd0: s = 3'd4;
      3'd1: s = 3'd6;
      3'd2: s = 3'd5;
      3'd3: s = 3'd5;
      3'd4: s = 3'd3;
      3'd5: s = 3'd1;
      3'd6: s = 3'd2;
      default: s = 3'd2;
    endcase
    return s;
  endfunction

  // switching pattern of active vector i, bit 2 is phase u
  function automatic logic [2:0] vec_pattern(input logic [2:0] i);
    logic [2:0] p;
    unique case (i)
      3'd0: p = 3'b100;
      3'd1: p = 3'b110;
      3'd2: p = 3'b010;
      3'd3: p = 3'b011;
      3'd4: p = 3'b001;
      3'd5: p = 3'b101;
      default: p = 3'b000;
    endcase
    return p;
  endfunction

  function automatic logic signed [16:0] sin60(input logic [2:0] s);
    logic signed [16:0] v;
    unique case (s)
      3'd1, 3'd2: v = HALF_SQRT3;
      3'd4, 3'd5: v = -HALF_SQRT3;
      default:    v = 17'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [16:0] cos60(input logic [2:0] s);
    logic signed [16:0] v;
    unique case (s)
      3'd1, 3'd5: v = 17'sd16384;
      3'd2, 3'd4: v = -17'sd16384;
      3'd3:       v = -17'sd32768;
      default:    v = 17'sd32768;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: hdl/svpwm_front.sv
// front end: accepts beats, tests the d/q length and scales long vectors back
`default_nettype none
module svpwm_front import svpwm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        angle,
  input  logic signed [15:0] d_cmd,
  input  logic signed [15:0] q_cmd,
  input  logic [14:0]        lim,
  output logic               push,
  output svpwm_item_t        push_item,
  input  logic               q_full
);

  localparam logic [2:0] IT_IDLE = 3'd0;
  localparam logic [2:0] IT_SQRT = 3'd1;
  localparam logic [2:0] IT_MUL  = 3'd2;
  localparam logic [2:0] IT_DIV  = 3'd3;
  localparam logic [2:0] IT_DONE = 3'd4;

  // stage 1: captured beat
  logic               v1_r;
  logic [15:0]        ang1_r;
  logic signed [15:0] d1_r, q1_r;
  logic [14:0]        lim1_r;
  // stage 2: squares
  logic               v2_r;
  logic [15:0]        ang2_r;
  logic signed [15:0] d2_r, q2_r;
  logic [14:0]        lim2_r;
  logic [30:0]        dd2_r, qq2_r;
  logic [29:0]        ll2_r;

  logic signed [31:0] dd_full, qq_full;
  logic [29:0]        ll_full;
  logic [31:0]        sum2;
  logic               lim_hit, adv1, adv2, free2, accept, it_idle;

  // iterative limiter
  logic [2:0]  it_state_r;
  logic [3:0]  cnt_r;
  logic [31:0] rad_r;
  logic [17:0] rem_r;
  logic [15:0] root_r;
  logic [15:0] it_ang_r;
  logic        dneg_r, qneg_r;
  logic [15:0] dabs_r, qabs_r;
  logic [14:0] it_lim_r;
  logic [15:0] nd_r, nq_r;
  logic [15:0] remd_r, remq_r;
  logic [15:0] qd_r, qq_r;

  logic [19:0] sq_ext, sq_trial;
  logic [30:0] prod_d, prod_q;
  logic [16:0] dv_ext_d, dv_ext_q;
  logic        dv_bit_d, dv_bit_q;
  logic [16:0] d_ext, q_ext;

  assign dd_full = d1_r * d1_r;
  assign qq_full = q1_r * q1_r;
  assign ll_full = lim1_r * lim1_r;

  assign sum2    = {1'b0, dd2_r} + {1'b0, qq2_r};
  assign lim_hit = sum2 > {2'b00, ll2_r};
  assign it_idle = (it_state_r == IT_IDLE);
  assign adv2    = v2_r && it_idle && (lim_hit || !q_full);
  assign free2   = !v2_r || adv2;
  assign adv1    = v1_r && free2;
  assign busy    = v1_r && !free2;
  assign accept  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (accept) v1_r <= 1'b1;
      else if (adv1) v1_r <= 1'b0;
      if (adv1) v2_r <= 1'b1;
      else if (adv2) v2_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ang1_r <= angle;
      d1_r   <= d_cmd;
      q1_r   <= q_cmd;
      lim1_r <= lim;
    end
    if (adv1) begin
      ang2_r <= ang1_r;
      d2_r   <= d1_r;
      q2_r   <= q1_r;
      lim2_r <= lim1_r;
      dd2_r  <= dd_full[30:0];
      qq2_r  <= qq_full[30:0];
      ll2_r  <= ll_full;
    end
  end

  // square root, one result bit per cycle
  assign sq_ext   = {rem_r, rad_r[31:30]};
  assign sq_trial = {2'b00, root_r, 2'b01};

  assign prod_d = dabs_r * it_lim_r;
  assign prod_q = qabs_r * it_lim_r;

  // long division by the magnitude, one quotient bit per cycle
  assign dv_ext_d = {remd_r, nd_r[cnt_r]};
  assign dv_ext_q = {remq_r, nq_r[cnt_r]};
  assign dv_bit_d = dv_ext_d >= {1'b0, root_r};
  assign dv_bit_q = dv_ext_q >= {1'b0, root_r};

  assign d_ext = d2_r[15] ? (17'd0 - 17'(d2_r)) : 17'(d2_r);
  assign q_ext = q2_r[15] ? (17'd0 - 17'(q2_r)) : 17'(q2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_state_r <= IT_IDLE;
      cnt_r      <= 4'd0;
    end else begin
      unique case (it_state_r)
        IT_IDLE: begin
          if (adv2 && lim_hit) begin
            it_state_r <= IT_SQRT;
            cnt_r      <= 4'd15;
          end
        end
        IT_SQRT: begin
          cnt_r <= cnt_r - 4'd1;
          if (cnt_r == 4'd0) it_state_r <= IT_MUL;
        end
        IT_MUL: begin
          it_state_r <= IT_DIV;
          cnt_r      <= 4'd15;
        end
        IT_DIV: begin
          cnt_r <= cnt_r - 4'd1;
          if (cnt_r == 4'd0) it_state_r <= IT_DONE;
        end
        IT_DONE: begin
          if (!q_full) it_state_r <= IT_IDLE;
        end
        default: it_state_r <= IT_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (it_state_r)
      IT_IDLE: begin
        rad_r    <= sum2;
        rem_r    <= 18'd0;
        root_r   <= 16'd0;
        it_ang_r <= ang2_r;
        dneg_r   <= d2_r[15];
        qneg_r   <= q2_r[15];
        dabs_r   <= d_ext[15:0];
        qabs_r   <= q_ext[15:0];
        it_lim_r <= lim2_r;
      end
      IT_SQRT: begin
        rad_r <= {rad_r[29:0], 2'b00};
        if (sq_ext >= sq_trial) begin
          rem_r  <= 18'(sq_ext - sq_trial);
          root_r <= {root_r[14:0], 1'b1};
        end else begin
          rem_r  <= sq_ext[17:0];
          root_r <= {root_r[14:0], 1'b0};
        end
      end
      IT_MUL: begin
        nd_r   <= prod_d[15:0];
        nq_r   <= prod_q[15:0];
        remd_r <= {2'b00, prod_d[29:16]};
        remq_r <= {2'b00, prod_q[29:16]};
        qd_r   <= 16'd0;
        qq_r   <= 16'd0;
      end
      IT_DIV: begin
        remd_r <= dv_bit_d ? 16'(dv_ext_d - {1'b0, root_r}) : dv_ext_d[15:0];
        remq_r <= dv_bit_q ? 16'(dv_ext_q - {1'b0, root_r}) : dv_ext_q[15:0];
        qd_r   <= {qd_r[14:0], dv_bit_d};
        qq_r   <= {qq_r[14:0], dv_bit_q};
      end
      IT_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (it_state_r == IT_DONE) begin
      push              = !q_full;
      push_item.angle   = it_ang_r;
      push_item.d       = dneg_r ? (16'sd0 - $signed(qd_r)) : $signed(qd_r);
      push_item.q       = qneg_r ? (16'sd0 - $signed(qq_r)) : $signed(qq_r);
      push_item.limited = 1'b1;
    end else begin
      push              = adv2 && !lim_hit;
      push_item.angle   = ang2_r;
      push_item.d       = d2_r;
      push_item.q       = q2_r;
      push_item.limited = 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: hdl/svpwm_queue.sv
// two-entry queue between the front end and the modulator pipeline
`default_nettype none
module svpwm_queue import svpwm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  svpwm_item_t push_item,
  output logic        full,
  output logic        pop,
  output svpwm_item_t pop_item
);

  svpwm_item_t mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign pop      = (cnt_r != 2'd0);
  assign pop_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

endmodule
`default_nettype wire

// File: hdl/svpwm_back.sv
// modulator pipeline: sine/cosine, inverse park, sector and duty stages
`default_nettype none
module svpwm_back import svpwm_pkg::*; #(
  parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_v,
  input  svpwm_item_t in_item,
  output logic        out_valid,
  output logic [15:0] duty_u,
  output logic [15:0] duty_v,
  output logic [15:0] duty_w,
  output logic [2:0]  sector,
  output logic        was_limited
);

  localparam int SH = 16 - $clog2(SINE_TABLE_ENTRIES);

  logic [10:0] v_r;

  // sine path, index 0 sine, index 1 cosine
  logic [14:0] z_r   [4][2];
  logic        neg_r [4][2];
  logic [14:0] z2_r  [2][2];
  logic [14:0] t1_r  [2];
  logic [15:0] t2_r  [2];
  logic signed [15:0] sc_r [2];

  logic signed [15:0] d_r [5];
  logic signed [15:0] q_r [5];
  logic               lim_r [10];

  logic signed [31:0] pdc_r, pqs_r, pds_r, pqc_r;
  logic signed [17:0] al7_r, be7_r, al8_r, be8_r, al9_r, be9_r;
  logic signed [35:0] a2_r, b2_r;
  logic               ka_r, kc_r;
  logic [2:0]         sec9_r, sec10_r;
  logic signed [35:0] tm_r, tn_r;
  logic [2:0]         pa_r, pb_r;

  logic [15:0] phase [2];
  logic [14:0] z_in [2];
  logic [29:0] m2 [2];
  logic [26:0] m3 [2];
  logic [29:0] m4 [2];
  logic [30:0] m5 [2];
  logic [14:0] s_clamp [2];
  logic signed [33:0] asum, bsum;
  logic        kb;
  logic [2:0]  sec_prev, sec_next;
  logic signed [38:0] x [3];
  logic signed [38:0] xr [3];
  logic [15:0] duty [3];

  assign phase[0] = (in_item.angle >> SH) << SH;
  assign phase[1] = phase[0] + 16'd16384;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      z_in[k]    = phase[k][14] ? (15'd16384 - {1'b0, phase[k][13:0]})
                                : {1'b0, phase[k][13:0]};
      m2[k]      = z_r[0][k] * z_r[0][k];
      m3[k]      = z2_r[0][k] * SIN_C;
      m4[k]      = z2_r[1][k] * t1_r[k];
      m5[k]      = z_r[3][k] * t2_r[k];
      s_clamp[k] = (m5[k][29:14] > 16'd32767) ? 15'h7fff : m5[k][28:14];
    end
  end

  assign asum = 34'(pdc_r) - 34'(pqs_r) + 34'sd16384;
  assign bsum = 34'(pds_r) + 34'(pqc_r) + 34'sd16384;
  assign kb   = b2_r > (a2_r + (a2_r <<< 1));

  // the two active vectors of the sector entering the dwell stage
  assign sec_prev = sec9_r - 3'd1;
  assign sec_next = (sec9_r == 3'd6) ? 3'd0 : sec9_r;

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      x[p] = (39'sd1 <<< 30) - 39'(tm_r) - 39'(tn_r)
           + (pa_r[2-p] ? (39'(tm_r) <<< 1) : 39'sd0)
           + (pb_r[2-p] ? (39'(tn_r) <<< 1) : 39'sd0);
      xr[p] = x[p] + 39'sd16384;
      if (xr[p][38])
        duty[p] = 16'd0;
      else if (|xr[p][37:31])
        duty[p] = 16'hffff;
      else
        duty[p] = xr[p][30:15];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[9:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    // phase fold
    for (int k = 0; k < 2; k++) begin
      z_r[0][k]   <= z_in[k];
      neg_r[0][k] <= phase[k][15];
      for (int s = 1; s < 4; s++) begin
        z_r[s][k]   <= z_r[s-1][k];
        neg_r[s][k] <= neg_r[s-1][k];
      end
      z2_r[0][k] <= m2[k][28:14];
      z2_r[1][k] <= z2_r[0][k];
      t1_r[k]    <= SIN_B - 15'(m3[k][26:14]);
      t2_r[k]    <= SIN_A - {1'b0, m4[k][28:14]};
      sc_r[k]    <= neg_r[3][k] ? (16'sd0 - $signed({1'b0, s_clamp[k]}))
                                : $signed({1'b0, s_clamp[k]});
    end
    d_r[0]   <= in_item.d;
    q_r[0]   <= in_item.q;
    lim_r[0] <= in_item.limited;
    for (int s = 1; s < 5; s++) begin
      d_r[s] <= d_r[s-1];
      q_r[s] <= q_r[s-1];
    end
    for (int s = 1; s < 10; s++) lim_r[s] <= lim_r[s-1];
    // inverse park
    pdc_r <= d_r[4] * sc_r[1];
    pqs_r <= q_r[4] * sc_r[0];
    pds_r <= d_r[4] * sc_r[0];
    pqc_r <= q_r[4] * sc_r[1];
    al7_r <= asum[32:15];
    be7_r <= bsum[32:15];
    // sector tests
    a2_r  <= al7_r * al7_r;
    b2_r  <= be7_r * be7_r;
    ka_r  <= be7_r > 18'sd0;
    kc_r  <= al7_r > 18'sd0;
    al8_r <= al7_r;
    be8_r <= be7_r;
    sec9_r <= sector_of_k({ka_r, kb, kc_r});
    al9_r  <= al8_r;
    be9_r  <= be8_r;
    // dwell times
    tm_r    <= sin60(sec9_r) * al9_r - cos60(sec9_r) * be9_r;
    tn_r    <= cos60(sec_prev) * be9_r - sin60(sec_prev) * al9_r;
    sec10_r <= sec9_r;
    pa_r    <= vec_pattern(sec_prev);
    pb_r    <= vec_pattern(sec_next);
    sector      <= sec10_r;
    was_limited <= lim_r[9];
    duty_u      <= duty[0];
    duty_v      <= duty[1];
    duty_w      <= duty[2];
  end

  assign out_valid = v_r[10];

endmodule
`default_nettype wire

// File: hdl/space_vector_pwm_dq.sv
// top level of the space vector pwm block with d/q inputs
// Usage:
//   Input: present in_rotor_angle, in_d_command and in_q_command with start high;
//   the beat is taken at a rising edge where start is high and busy is low.
//   Config: cfg_we with cfg_wdata writes the d/q magnitude limit (Q0.15).
//   Output: out_valid pulses for one cycle with the three duties, the sector
//   and out_was_limited; the receiver cannot hold results off.
// Path: a beat passes the capture and squares stages, the two-entry queue
//   and the modulator pipeline to out_valid; a vector over the limit also
//   passes the limiter (square root, multiply, divide, hand-off).
// Throughput: one beat per cycle while vectors stay within the limit and the
//   queue is not full; a limited vector holds the front end until the
//   shared bit-serial square root and divider are done.
// Reset: synchronous on rst_n low; the limit returns to 0.85, all beats in
//   flight are dropped and busy goes low.
`default_nettype none
module space_vector_pwm_dq import svpwm_pkg::*; #(
  parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        in_rotor_angle,
  input  logic signed [15:0] in_d_command,
  input  logic signed [15:0] in_q_command,
  input  logic               cfg_we,
  input  logic [14:0]        cfg_wdata,
  output logic               out_valid,
  output logic [15:0]        out_duty_u,
  output logic [15:0]        out_duty_v,
  output logic [15:0]        out_duty_w,
  output logic [2:0]         out_sector,
  output logic               out_was_limited
);

  logic [14:0] lim_r;
  logic        push, q_full, pop;
  svpwm_item_t push_item, pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      lim_r <= cfg_wdata;
    end
  end

  svpwm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .angle     (in_rotor_angle),
    .d_cmd     (in_d_command),
    .q_cmd     (in_q_command),
    .lim       (lim_r),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  svpwm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item)
  );

  svpwm_back #(
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_v        (pop),
    .in_item     (pop_item),
    .out_valid   (out_valid),
    .duty_u      (out_duty_u),
    .duty_v      (out_duty_v),
    .duty_w      (out_duty_w),
    .sector      (out_sector),
    .was_limited (out_was_limited)
  );

endmodule
`default_nettype wire

// File: hdl/svpwm_check.sv
// port-level checker for the space vector pwm block, bound to the top level
`default_nettype none
`include "space_vector_pwm_dq_macros.svh"
module svpwm_check (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic [2:0]  out_sector
);

  `SVP_ASSERT_IMP(a_sector_range, out_valid, (out_sector >= 3'd1) && (out_sector <= 3'd6))
  `SVP_ASSERT_NXT(a_reset_no_strobe, !rst_n, !out_valid)
  `SVP_ASSERT_NXT(a_reset_not_busy, !rst_n, !busy)

endmodule

bind space_vector_pwm_dq svpwm_check u_svpwm_check (.*);
`default_nettype wire
